[hw/rtl/erbcf_pkg.sv]
// Package for the ERB-rate center frequency generator.
// Holds the request and result types, controller codes and fixed-point constants.
// Used by erbcf_ctrl, erbcf_dpath and the top level.
package erbcf_pkg;

    typedef struct packed {
        logic [6:0]  channel_count;
        logic [19:0] low_frequency;
        logic [19:0] high_frequency;
    } t_request;

    typedef struct packed {
        logic [5:0]  channel_index;
        logic [19:0] center_frequency;
        logic        last_channel;
    } t_result;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_LOG_MUL,
        OP_LOG_NORM,
        OP_SQ_MUL,
        OP_SQ_UPD,
        OP_ERB_MUL,
        OP_ERB_STORE,
        OP_SPAN,
        OP_NUM_MUL,
        OP_NUM,
        OP_DIV_STEP,
        OP_EPT,
        OP_TL_MUL,
        OP_TL_ACC,
        OP_TH_MUL,
        OP_TH_ACC,
        OP_Z_MUL,
        OP_Z,
        OP_TERM_MUL,
        OP_TERM_X,
        OP_DK_MUL,
        OP_DK,
        OP_V,
        OP_HZ_MUL,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_LOG_MUL,
        S_LOG_NORM,
        S_SQ_MUL,
        S_SQ_UPD,
        S_ERB_MUL,
        S_ERB_STORE,
        S_SPAN,
        S_NUM_MUL,
        S_NUM,
        S_DIV,
        S_EPT,
        S_TL_MUL,
        S_TL_ACC,
        S_TH_MUL,
        S_TH_ACC,
        S_Z_MUL,
        S_Z,
        S_TERM_MUL,
        S_TERM_X,
        S_DK_MUL,
        S_DK,
        S_V,
        S_HZ_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic       sel_hi;
        logic [4:0] k;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic last;
    } t_status;

    localparam int SQ_STEPS    = 28;
    localparam int DIV_STEPS   = 31;
    localparam int TERMS_LAST  = 23;

    localparam logic [24:0] COEF_Q32         = 25'd18769007;
    localparam logic [30:0] ERB_PER_LOG2_Q28 = 31'd1729272457;
    localparam logic [37:0] LOG2_PER_ERB_Q40 = 38'd170677503129;
    localparam logic [29:0] LN2_Q30          = 30'd744261118;
    localparam logic [29:0] HZ_SCALE_Q18     = 30'd959794966;
    localparam logic [19:0] FREQ_MAX         = 20'hFFFFF;

    // floor((2^32 - 1) / k) for the series divisors.
    function automatic logic [31:0] recip(input logic [4:0] k);
        logic [31:0] r;
        case (k)
            5'd1:    r = 32'd4294967295;
            5'd2:    r = 32'd2147483647;
            5'd3:    r = 32'd1431655765;
            5'd4:    r = 32'd1073741823;
            5'd5:    r = 32'd858993459;
            5'd6:    r = 32'd715827882;
            5'd7:    r = 32'd613566756;
            5'd8:    r = 32'd536870911;
            5'd9:    r = 32'd477218588;
            5'd10:   r = 32'd429496729;
            5'd11:   r = 32'd390451572;
            5'd12:   r = 32'd357913941;
            5'd13:   r = 32'd330382099;
            5'd14:   r = 32'd306783378;
            5'd15:   r = 32'd286331153;
            5'd16:   r = 32'd268435455;
            5'd17:   r = 32'd252645135;
            5'd18:   r = 32'd238609294;
            5'd19:   r = 32'd226050910;
            5'd20:   r = 32'd214748364;
            5'd21:   r = 32'd204522252;
            5'd22:   r = 32'd195225786;
            5'd23:   r = 32'd186737708;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/erbcf_ctrl.sv]
// Sequencer for the ERB-rate center frequency generator.
// Steps the datapath through log, span division and exponential per channel.
// Depends on erbcf_pkg.
module erbcf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  erbcf_pkg::t_status i_status,
    output erbcf_pkg::t_cmd   o_cmd,
    output logic              o_busy
);

    erbcf_pkg::t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_sel, n_sel;
    logic [4:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= erbcf_pkg::S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
            r_k     <= 5'd1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        n_k     = r_k;
        case (r_state)
            erbcf_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = erbcf_pkg::S_CHECK;
                end
            end
            erbcf_pkg::S_CHECK: begin
                n_sel = 1'b0;
                if (i_status.n_zero) begin
                    n_state = erbcf_pkg::S_IDLE;
                end else begin
                    n_state = erbcf_pkg::S_LOG_MUL;
                end
            end
            erbcf_pkg::S_LOG_MUL:  n_state = erbcf_pkg::S_LOG_NORM;
            erbcf_pkg::S_LOG_NORM: begin
                n_cnt   = '0;
                n_state = erbcf_pkg::S_SQ_MUL;
            end
            erbcf_pkg::S_SQ_MUL:   n_state = erbcf_pkg::S_SQ_UPD;
            erbcf_pkg::S_SQ_UPD: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(erbcf_pkg::SQ_STEPS - 1)) begin
                    n_state = erbcf_pkg::S_ERB_MUL;
                end else begin
                    n_state = erbcf_pkg::S_SQ_MUL;
                end
            end
            erbcf_pkg::S_ERB_MUL:  n_state = erbcf_pkg::S_ERB_STORE;
            erbcf_pkg::S_ERB_STORE: begin
                if (r_sel) begin
                    n_state = erbcf_pkg::S_SPAN;
                end else begin
                    n_sel   = 1'b1;
                    n_state = erbcf_pkg::S_LOG_MUL;
                end
            end
            erbcf_pkg::S_SPAN:     n_state = erbcf_pkg::S_NUM_MUL;
            erbcf_pkg::S_NUM_MUL:  n_state = erbcf_pkg::S_NUM;
            erbcf_pkg::S_NUM: begin
                n_cnt   = '0;
                n_state = erbcf_pkg::S_DIV;
            end
            erbcf_pkg::S_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(erbcf_pkg::DIV_STEPS - 1)) begin
                    n_state = erbcf_pkg::S_EPT;
                end
            end
            erbcf_pkg::S_EPT:      n_state = erbcf_pkg::S_TL_MUL;
            erbcf_pkg::S_TL_MUL:   n_state = erbcf_pkg::S_TL_ACC;
            erbcf_pkg::S_TL_ACC:   n_state = erbcf_pkg::S_TH_MUL;
            erbcf_pkg::S_TH_MUL:   n_state = erbcf_pkg::S_TH_ACC;
            erbcf_pkg::S_TH_ACC:   n_state = erbcf_pkg::S_Z_MUL;
            erbcf_pkg::S_Z_MUL:    n_state = erbcf_pkg::S_Z;
            erbcf_pkg::S_Z: begin
                n_k     = 5'd1;
                n_state = erbcf_pkg::S_TERM_MUL;
            end
            erbcf_pkg::S_TERM_MUL: n_state = erbcf_pkg::S_TERM_X;
            erbcf_pkg::S_TERM_X:   n_state = erbcf_pkg::S_DK_MUL;
            erbcf_pkg::S_DK_MUL:   n_state = erbcf_pkg::S_DK;
            erbcf_pkg::S_DK: begin
                if (r_k == 5'(erbcf_pkg::TERMS_LAST)) begin
                    n_state = erbcf_pkg::S_V;
                end else begin
                    n_k     = r_k + 5'd1;
                    n_state = erbcf_pkg::S_TERM_MUL;
                end
            end
            erbcf_pkg::S_V:        n_state = erbcf_pkg::S_HZ_MUL;
            erbcf_pkg::S_HZ_MUL:   n_state = erbcf_pkg::S_OUT;
            erbcf_pkg::S_OUT: begin
                if (i_status.last) begin
                    n_state = erbcf_pkg::S_IDLE;
                end else begin
                    n_state = erbcf_pkg::S_NUM_MUL;
                end
            end
            default:               n_state = erbcf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.sel_hi = r_sel;
        o_cmd.k      = r_k;
        o_busy       = (r_state != erbcf_pkg::S_IDLE);
        case (r_state)
            erbcf_pkg::S_IDLE:      o_cmd.op = i_start ? erbcf_pkg::OP_LOAD : erbcf_pkg::OP_NOP;
            erbcf_pkg::S_LOG_MUL:   o_cmd.op = erbcf_pkg::OP_LOG_MUL;
            erbcf_pkg::S_LOG_NORM:  o_cmd.op = erbcf_pkg::OP_LOG_NORM;
            erbcf_pkg::S_SQ_MUL:    o_cmd.op = erbcf_pkg::OP_SQ_MUL;
            erbcf_pkg::S_SQ_UPD:    o_cmd.op = erbcf_pkg::OP_SQ_UPD;
            erbcf_pkg::S_ERB_MUL:   o_cmd.op = erbcf_pkg::OP_ERB_MUL;
            erbcf_pkg::S_ERB_STORE: o_cmd.op = erbcf_pkg::OP_ERB_STORE;
            erbcf_pkg::S_SPAN:      o_cmd.op = erbcf_pkg::OP_SPAN;
            erbcf_pkg::S_NUM_MUL:   o_cmd.op = erbcf_pkg::OP_NUM_MUL;
            erbcf_pkg::S_NUM:       o_cmd.op = erbcf_pkg::OP_NUM;
            erbcf_pkg::S_DIV:       o_cmd.op = erbcf_pkg::OP_DIV_STEP;
            erbcf_pkg::S_EPT:       o_cmd.op = erbcf_pkg::OP_EPT;
            erbcf_pkg::S_TL_MUL:    o_cmd.op = erbcf_pkg::OP_TL_MUL;
            erbcf_pkg::S_TL_ACC:    o_cmd.op = erbcf_pkg::OP_TL_ACC;
            erbcf_pkg::S_TH_MUL:    o_cmd.op = erbcf_pkg::OP_TH_MUL;
            erbcf_pkg::S_TH_ACC:    o_cmd.op = erbcf_pkg::OP_TH_ACC;
            erbcf_pkg::S_Z_MUL:     o_cmd.op = erbcf_pkg::OP_Z_MUL;
            erbcf_pkg::S_Z:         o_cmd.op = erbcf_pkg::OP_Z;
            erbcf_pkg::S_TERM_MUL:  o_cmd.op = erbcf_pkg::OP_TERM_MUL;
            erbcf_pkg::S_TERM_X:    o_cmd.op = erbcf_pkg::OP_TERM_X;
            erbcf_pkg::S_DK_MUL:    o_cmd.op = erbcf_pkg::OP_DK_MUL;
            erbcf_pkg::S_DK:        o_cmd.op = erbcf_pkg::OP_DK;
            erbcf_pkg::S_V:         o_cmd.op = erbcf_pkg::OP_V;
            erbcf_pkg::S_HZ_MUL:    o_cmd.op = erbcf_pkg::OP_HZ_MUL;
            erbcf_pkg::S_OUT:       o_cmd.op = erbcf_pkg::OP_OUT;
            default:                o_cmd.op = erbcf_pkg::OP_NOP;
        endcase
    end

endmodule

[hw/rtl/erbcf_dpath.sv]
// Datapath of the ERB-rate center frequency generator.
// One shared registered multiplier, a bit-serial divider and the working registers.
// Depends on erbcf_pkg.
module erbcf_dpath #(
    parameter int MAX_CHANNELS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  erbcf_pkg::t_cmd     i_cmd,
    input  erbcf_pkg::t_request i_request,
    output erbcf_pkg::t_status  o_status,
    output erbcf_pkg::t_result  o_result,
    output logic                o_strobe
);

    logic [6:0]  r_n;
    logic [19:0] r_f_lo, r_f_hi;
    logic [5:0]  r_i;
    logic [64:0] r_p;
    logic [32:0] mul_a;
    logic [31:0] mul_b;

    logic [30:0] r_y;
    logic [3:0]  r_pm;
    logic [27:0] r_frac;
    logic [22:0] r_e_lo, r_e_hi;
    logic signed [23:0] r_d;

    logic [30:0] r_quo;
    logic [6:0]  r_rem;
    logic        r_neg;

    logic [24:0] r_e;
    logic        r_zero, r_big, r_low;
    logic [43:0] r_acc;
    logic [3:0]  r_sh;
    logic [27:0] r_r;
    logic [29:0] r_z;
    logic [30:0] r_term;
    logic [29:0] r_x;
    logic [31:0] r_sum;
    logic [32:0] r_vm;
    erbcf_pkg::t_result r_result;
    logic        r_strobe;

    logic [22:0] d_mag;
    logic [45:0] log_x;
    logic [3:0]  log_pm;
    logic [31:0] sq_s;
    logic [63:0] erb_rnd;
    logic signed [32:0] num_s;
    logic [7:0]  div_den, div_sh;
    logic signed [32:0] e_wide, q_s;
    logic [61:0] t_sum;
    logic [33:0] t_val;
    logic [29:0] dk_q;
    logic [34:0] dk_rem;
    logic [39:0] v_sh;
    logic [33:0] v_val;
    logic [64:0] hz_rnd;
    logic [22:0] hz_res;
    logic [19:0] freq;

    assign d_mag   = r_d[23] ? 23'(-r_d) : r_d[22:0];
    assign div_den = {r_n, 1'b0};
    assign div_sh  = {r_rem, r_quo[30]};

    // Leading-one search over the few possible exponent positions.
    always_comb begin
        log_x  = 46'(64'd1 << 36) + r_p[45:0];
        log_pm = '0;
        for (int j = 0; j < 10; j++) begin
            if (log_x[36 + j]) begin
                log_pm = 4'(j);
            end
        end
    end

    assign sq_s    = r_p[61:30];
    assign erb_rnd = r_p[63:0] + (64'd1 << 39);
    assign num_s   = r_d[23] ? (33'(r_n) - 33'(r_p[29:0])) : (33'(r_p[29:0]) + 33'(r_n));
    assign q_s     = r_neg ? -(33'(r_quo) + 33'(r_rem != '0)) : 33'(r_quo);
    assign e_wide  = 33'(r_e_lo) + q_s;
    assign t_sum   = 62'(r_acc) + {r_p[41:0], 20'd0};
    assign t_val   = t_sum[61:28];
    assign dk_q    = r_p[61:32];
    assign dk_rem  = 35'(r_x) - (35'(dk_q) * 35'(i_cmd.k));
    assign v_sh    = 40'(r_sum) << r_sh;
    assign v_val   = v_sh[39:6];
    assign hz_rnd  = r_p + (65'd1 << 41);
    assign hz_res  = hz_rnd[64:42];

    always_comb begin
        if (r_zero) begin
            freq = '0;
        end else if (r_big) begin
            freq = erbcf_pkg::FREQ_MAX;
        end else if (r_low) begin
            freq = '0;
        end else if (hz_res > 23'(erbcf_pkg::FREQ_MAX)) begin
            freq = erbcf_pkg::FREQ_MAX;
        end else begin
            freq = hz_res[19:0];
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            erbcf_pkg::OP_LOG_MUL: begin
                mul_a = 33'(i_cmd.sel_hi ? r_f_hi : r_f_lo);
                mul_b = 32'(erbcf_pkg::COEF_Q32);
            end
            erbcf_pkg::OP_SQ_MUL: begin
                mul_a = 33'(r_y);
                mul_b = 32'(r_y);
            end
            erbcf_pkg::OP_ERB_MUL: begin
                mul_a = {1'b0, r_pm, r_frac};
                mul_b = 32'(erbcf_pkg::ERB_PER_LOG2_Q28);
            end
            erbcf_pkg::OP_NUM_MUL: begin
                mul_a = 33'(d_mag);
                mul_b = 32'({r_i, 1'b1});
            end
            erbcf_pkg::OP_TL_MUL: begin
                mul_a = 33'(r_e[22:0]);
                mul_b = 32'(erbcf_pkg::LOG2_PER_ERB_Q40[19:0]);
            end
            erbcf_pkg::OP_TH_MUL: begin
                mul_a = 33'(r_e[22:0]);
                mul_b = 32'(erbcf_pkg::LOG2_PER_ERB_Q40[37:20]);
            end
            erbcf_pkg::OP_Z_MUL: begin
                mul_a = 33'(r_r);
                mul_b = 32'(erbcf_pkg::LN2_Q30);
            end
            erbcf_pkg::OP_TERM_MUL: begin
                mul_a = 33'(r_term);
                mul_b = 32'(r_z);
            end
            erbcf_pkg::OP_DK_MUL: begin
                mul_a = 33'(r_x);
                mul_b = erbcf_pkg::recip(i_cmd.k);
            end
            erbcf_pkg::OP_HZ_MUL: begin
                mul_a = r_vm;
                mul_b = 32'(erbcf_pkg::HZ_SCALE_Q18);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p <= 65'(mul_a) * 65'(mul_b);
        case (i_cmd.op)
            erbcf_pkg::OP_LOAD: begin
                r_n    <= (i_request.channel_count > 7'(MAX_CHANNELS)) ?
                          7'(MAX_CHANNELS) : i_request.channel_count;
                r_f_lo <= i_request.low_frequency;
                r_f_hi <= i_request.high_frequency;
            end
            erbcf_pkg::OP_LOG_NORM: begin
                r_y    <= 31'(log_x >> (log_pm + 4'd6));
                r_pm   <= log_pm;
                r_frac <= '0;
            end
            erbcf_pkg::OP_SQ_UPD: begin
                r_frac <= {r_frac[26:0], sq_s[31]};
                r_y    <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
            end
            erbcf_pkg::OP_ERB_STORE: begin
                if (i_cmd.sel_hi) begin
                    r_e_hi <= erb_rnd[62:40];
                end else begin
                    r_e_lo <= erb_rnd[62:40];
                end
            end
            erbcf_pkg::OP_SPAN: begin
                r_d <= $signed({1'b0, r_e_hi}) - $signed({1'b0, r_e_lo});
                r_i <= '0;
            end
            erbcf_pkg::OP_NUM: begin
                r_neg <= num_s[32];
                r_quo <= num_s[32] ? 31'(-num_s) : num_s[30:0];
                r_rem <= '0;
            end
            erbcf_pkg::OP_DIV_STEP: begin
                if (div_sh >= div_den) begin
                    r_rem <= 7'(div_sh - div_den);
                    r_quo <= {r_quo[29:0], 1'b1};
                end else begin
                    r_rem <= div_sh[6:0];
                    r_quo <= {r_quo[29:0], 1'b0};
                end
            end
            erbcf_pkg::OP_EPT: begin
                r_e    <= e_wide[24:0];
                r_zero <= (e_wide <= 33'sd0);
                r_big  <= (e_wide >= 33'sd8388608);
            end
            erbcf_pkg::OP_TL_ACC: begin
                r_acc <= r_p[43:0] + (44'd1 << 27);
            end
            erbcf_pkg::OP_TH_ACC: begin
                r_sh <= t_val[31:28];
                r_r  <= t_val[27:0];
                if (t_val[33:28] > 6'd8) begin
                    r_big <= 1'b1;
                end
            end
            erbcf_pkg::OP_Z: begin
                r_z    <= r_p[57:28];
                r_sum  <= 32'd1 << 30;
                r_term <= 31'd1 << 30;
            end
            erbcf_pkg::OP_TERM_X: begin
                r_x <= r_p[59:30];
            end
            erbcf_pkg::OP_DK: begin
                // The reciprocal estimate is at most one short.
                if (dk_rem >= 35'(i_cmd.k)) begin
                    r_term <= 31'(dk_q) + 31'd1;
                    r_sum  <= r_sum + 32'(dk_q) + 32'd1;
                end else begin
                    r_term <= 31'(dk_q);
                    r_sum  <= r_sum + 32'(dk_q);
                end
            end
            erbcf_pkg::OP_V: begin
                r_low <= (v_val <= 34'(24'd0) + (34'd1 << 24));
                r_vm  <= 33'(v_val - (34'd1 << 24));
            end
            erbcf_pkg::OP_OUT: begin
                r_result.channel_index    <= r_i;
                r_result.center_frequency <= freq;
                r_result.last_channel     <= o_status.last;
                r_i                       <= r_i + 6'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == erbcf_pkg::OP_OUT);
        end
    end

    assign o_status.n_zero = (r_n == '0);
    assign o_status.last   = ({1'b0, r_i} == (r_n - 7'd1));
    assign o_result        = r_result;
    assign o_strobe        = r_strobe;

endmodule

[hw/rtl/erb_center_frequency_generator_top.sv]
// ERB-rate center frequency generator: one request gives one result per channel, with
// channel_count saturated at MAX_CHANNELS. Busy stays high while the request runs: first
// two 28-step log loops, then per channel a 31-step divide and a 23-term exponential
// series, each term passing through the TERM_MUL, TERM_X, DK_MUL and DK states. Results
// come one channel at a time; busy falls as the last one appears on o_strobe.
// Results appear for one cycle on o_strobe. Synchronous active-low reset returns to idle.
module erb_center_frequency_generator_top #(
    parameter int MAX_CHANNELS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  erbcf_pkg::t_request i_request,
    output erbcf_pkg::t_result  o_result,
    output logic                o_strobe
);

    erbcf_pkg::t_cmd    cmd;
    erbcf_pkg::t_status status;

    erbcf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    erbcf_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_request (i_request),
        .o_status  (status),
        .o_result  (o_result),
        .o_strobe  (o_strobe)
    );

endmodule
